FILE: hdl/rau_pkg.sv
// Package for the rational arithmetic unit: widths, action codes, sequencer states.
// No dependencies.
`default_nettype none
package rau_pkg;
	localparam int WORD_BITS_DEF = 32;
	localparam int ACT_W = 3;
	localparam int ORD_W = 2;

	typedef enum logic [ACT_W-1:0] {
		ACT_ADD = 3'd0,
		ACT_SUB = 3'd1,
		ACT_MUL = 3'd2,
		ACT_DIV = 3'd3,
		ACT_CMP = 3'd4
	} action_t;

	localparam logic [ORD_W-1:0] ORD_LESS  = 2'd0;
	localparam logic [ORD_W-1:0] ORD_EQUAL = 2'd1;
	localparam logic [ORD_W-1:0] ORD_GREAT = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_COMB,
		ST_GCD,
		ST_DIVN,
		ST_DIVD,
		ST_FIN
	} state_t;
endpackage
`default_nettype wire

FILE: hdl/rau_divider.sv
// Restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on nothing outside this file.
`default_nettype none
module rau_divider #(
	parameter int W = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         go,
	input  wire logic [W-1:0] dividend,
	input  wire logic [W-1:0] divisor,
	output logic              done,
	output logic [W-1:0]      quotient,
	output logic [W-1:0]      remainder
);
	localparam int CW = $clog2(W + 1);
	logic [CW-1:0] cnt_q;
	logic          run_q;
	logic [W-1:0]  quo_q, rem_q, dsr_q;
	logic [W:0]    trial;
	logic [W:0]    shifted;

	assign shifted = {rem_q, quo_q[W-1]};
	assign trial = shifted - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (go) begin
				run_q <= 1'b1;
				cnt_q <= CW'(W);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					run_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			quo_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (run_q) begin
			if (!trial[W]) begin
				rem_q <= trial[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b1};
			end else begin
				rem_q <= shifted[W-1:0];
				quo_q <= {quo_q[W-2:0], 1'b0};
			end
		end
	end

	assign quotient = quo_q;
	assign remainder = rem_q;
endmodule
`default_nettype wire

FILE: hdl/rational_arithmetic_unit.sv
// Rational arithmetic unit top level: sequencer, shared multiplier and divider.
// Depends on rau_pkg and rau_divider.
//
// An item is taken when start is high and busy low; its result shows on the output
// ports for one cycle with done high and cannot be stalled. Each item takes three
// multiply steps MUL1, MUL2 and MUL3 on one shared multiplier, a combine step, then one
// pass of the shared bit-serial divider for every Euclidean remainder step, and two
// more passes to divide the numerator and denominator by the gcd; a zero numerator
// skips the remainder steps. Compare items, items with the spare action codes above
// compare, and zero-denominator items finish after the combine step. busy is low
// again in the cycle that shows done.
`default_nettype none
module rational_arithmetic_unit #(
	parameter int WORD_BITS = rau_pkg::WORD_BITS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	output logic                            busy,
	input  wire logic [rau_pkg::ACT_W-1:0]  action,
	input  wire logic signed [31:0]         a_num,
	input  wire logic [30:0]                a_den,
	input  wire logic signed [31:0]         b_num,
	input  wire logic [30:0]                b_den,
	output logic                            done,
	output logic signed [31:0]              r_num,
	output logic [30:0]                     r_den,
	output logic [rau_pkg::ORD_W-1:0]       order,
	output logic                            zero_divide,
	output logic                            overflow
);
	import rau_pkg::*;
	localparam int PW = 2 * WORD_BITS + 2;
	localparam int DW = 2 * WORD_BITS;

	state_t st_q, st_d;
	logic [ACT_W-1:0] act_q;
	logic signed [WORD_BITS:0] an_q, bn_q;
	logic signed [WORD_BITS:0] ad_q, bd_q;
	logic signed [PW-1:0] p_q, q_q, num_q, den_q;
	logic [DW-1:0] x_q, y_q, mn_q, md_q;
	logic neg_q;

	// shared multiplier, one product per cycle
	logic signed [WORD_BITS:0] ma, mb;
	logic signed [PW-1:0] mprod;
	assign mprod = PW'(ma) * PW'(mb);
	always_comb begin
		ma = ad_q;
		mb = bd_q;
		if (st_q == ST_MUL1) begin
			ma = an_q;
			mb = (act_q == ACT_MUL) ? bn_q : bd_q;
		end else if (st_q == ST_MUL2) begin
			ma = bn_q;
			mb = ad_q;
		end
	end

	logic dv_go, dv_done;
	logic [DW-1:0] dv_a, dv_b, dv_quo, dv_rem;
	rau_divider #(.W(DW)) u_div (
		.clk(clk), .arst_n(arst_n), .go(dv_go), .dividend(dv_a), .divisor(dv_b),
		.done(dv_done), .quotient(dv_quo), .remainder(dv_rem)
	);

	logic [PW-1:0] anum, aden;
	logic [DW-1:0] lim;
	logic [DW-1:0] qmn, qmd;
	logic        fin_neg, ovf_c;
	assign anum = num_q[PW-1] ? PW'(-num_q) : PW'(num_q);
	assign aden = den_q[PW-1] ? PW'(-den_q) : PW'(den_q);
	assign lim = DW'(1) << (WORD_BITS - 1);
	always_comb begin
		qmn = mn_q;
		qmd = md_q;
		fin_neg = neg_q;
		if (qmn == '0) begin
			fin_neg = 1'b0;
			qmd = DW'(1);
		end
		ovf_c = (qmd > lim - DW'(1)) || (qmn > (fin_neg ? lim : lim - DW'(1)));
	end

	always_comb begin
		st_d = st_q;
		dv_go = 1'b0;
		dv_a = x_q;
		dv_b = y_q;
		unique case (st_q)
			ST_IDLE: if (start) st_d = ST_MUL1;
			ST_MUL1: st_d = ST_MUL2;
			ST_MUL2: st_d = ST_MUL3;
			ST_MUL3: st_d = ST_COMB;
			ST_COMB: begin
				if (act_q > ACT_DIV || den_q == '0) begin
					st_d = ST_FIN;
				end else if (anum[DW-1:0] == '0 || aden[DW-1:0] == '0) begin
					st_d = ST_DIVN;
					dv_go = 1'b1;
					dv_a = anum[DW-1:0];
					dv_b = (anum[DW-1:0] == '0) ? aden[DW-1:0] : anum[DW-1:0];
				end else begin
					st_d = ST_GCD;
					dv_go = 1'b1;
					dv_a = anum[DW-1:0];
					dv_b = aden[DW-1:0];
				end
			end
			ST_GCD: begin
				if (dv_done) begin
					if (dv_rem == '0) begin
						st_d = ST_DIVN;
						dv_go = 1'b1;
						dv_a = mn_q;
						dv_b = y_q;
					end else begin
						dv_go = 1'b1;
						dv_a = y_q;
						dv_b = dv_rem;
					end
				end
			end
			ST_DIVN: begin
				if (dv_done) begin
					st_d = ST_DIVD;
					dv_go = 1'b1;
					dv_a = md_q;
					dv_b = y_q;
				end
			end
			ST_DIVD: if (dv_done) st_d = ST_FIN;
			ST_FIN: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			st_q <= st_d;
			done <= (st_q == ST_FIN);
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				act_q <= action;
				an_q <= {a_num[WORD_BITS-1], a_num[WORD_BITS-1:0]};
				bn_q <= {b_num[WORD_BITS-1], b_num[WORD_BITS-1:0]};
				ad_q <= {2'b00, a_den[WORD_BITS-2:0]};
				bd_q <= {2'b00, b_den[WORD_BITS-2:0]};
			end
			ST_MUL1: p_q <= mprod;
			ST_MUL2: begin
				q_q <= mprod;
				if (act_q == ACT_ADD) num_q <= p_q + mprod;
				else if (act_q == ACT_SUB) num_q <= p_q - mprod;
				else num_q <= p_q;
			end
			// divide takes ad*bn from the second product
			ST_MUL3: den_q <= (act_q == ACT_DIV) ? q_q : mprod;
			ST_COMB: begin
				mn_q <= anum[DW-1:0];
				md_q <= aden[DW-1:0];
				neg_q <= num_q[PW-1] ^ den_q[PW-1];
				x_q <= anum[DW-1:0];
				y_q <= aden[DW-1:0];
			end
			ST_GCD: if (dv_done && dv_rem != '0) begin
				x_q <= y_q;
				y_q <= dv_rem;
			end
			ST_DIVN: if (dv_done) mn_q <= dv_quo;
			ST_DIVD: if (dv_done) md_q <= dv_quo;
			default: ;
		endcase
		if (st_q == ST_FIN) begin
			r_num <= '0;
			r_den <= 31'd1;
			order <= ORD_LESS;
			zero_divide <= 1'b0;
			overflow <= 1'b0;
			if (act_q > ACT_DIV) begin
				if (p_q < q_q) order <= ORD_LESS;
				else if (p_q == q_q) order <= ORD_EQUAL;
				else order <= ORD_GREAT;
			end else if (den_q == '0) begin
				zero_divide <= 1'b1;
			end else if (ovf_c) begin
				overflow <= 1'b1;
			end else begin
				r_num <= fin_neg ? 32'(-$signed({1'b0, qmn})) : 32'(qmn);
				r_den <= 31'(qmd);
			end
		end
	end

	assign busy = (st_q != ST_IDLE);
endmodule
`default_nettype wire

FILE: hdl/rau_checker.sv
// Port-level checker for the rational arithmetic unit, bound to the top level.
// Depends on rau_pkg.
`default_nettype none
module rau_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic        done,
	input wire logic [30:0] r_den,
	input wire logic [1:0]  order,
	input wire logic        zero_divide,
	input wire logic        overflow
);
	import rau_pkg::*;
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("no busy after accept");
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done twice");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("done while busy");
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !(zero_divide && overflow)) else $error("both flags");
	a_den: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (r_den != '0 && order != 2'd3)) else $error("bad result");
endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.r_den(r_den), .order(order), .zero_divide(zero_divide), .overflow(overflow)
);
`default_nettype wire

FILE: tb/testbench.sv
// Testbench for rational_arithmetic_unit: directed table then random words, each result
// checked against the row's given result or an in-bench fraction predictor. Depends on rau_pkg.
`default_nettype none
module testbench;
	import rau_pkg::*;

	localparam logic [ACT_W-1:0] ACT_SPARE5 = 3'd5;
	localparam logic [ACT_W-1:0] ACT_SPARE7 = 3'd7;
	localparam int N_RANDOM = 1630;

	typedef struct {
		logic [ACT_W-1:0]   action;
		logic signed [31:0] a_num;
		logic [30:0]        a_den;
		logic signed [31:0] b_num;
		logic [30:0]        b_den;
	} word_in_t;

	typedef struct {
		logic signed [31:0] r_num;
		logic [30:0]        r_den;
		logic [ORD_W-1:0]   order;
		logic               zero_divide;
		logic               overflow;
	} word_out_t;

	typedef struct {
		word_in_t  w;
		bit        typed;
		word_out_t r;
	} table_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [ACT_W-1:0] action = '0;
	logic signed [31:0] a_num = '0;
	logic [30:0] a_den = 31'd1;
	logic signed [31:0] b_num = '0;
	logic [30:0] b_den = 31'd1;
	logic done;
	logic signed [31:0] r_num;
	logic [30:0] r_den;
	logic [ORD_W-1:0] order;
	logic zero_divide;
	logic overflow;

	word_out_t fraction_q[$];
	int errors = 0;
	int n_results = 0;
	int n_ovf = 0;
	int n_zdiv = 0;
	bit driving_typed = 1'b0;
	word_out_t driving_result;

	rational_arithmetic_unit u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.action(action), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
		.done(done), .r_num(r_num), .r_den(r_den), .order(order),
		.zero_divide(zero_divide), .overflow(overflow)
	);

	always #5 clk = ~clk;

	function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	function automatic word_out_t reduce_fraction(word_in_t w);
		word_out_t r;
		longint an, ad, bn, bd, num, den, p, q;
		longint unsigned mn, md, g, lim;
		bit neg;
		an = longint'(w.a_num);
		ad = longint'(w.a_den);
		bn = longint'(w.b_num);
		bd = longint'(w.b_den);
		r = '{r_num: '0, r_den: 31'd1, order: ORD_LESS, zero_divide: 1'b0, overflow: 1'b0};
		num = 0;
		den = 1;
		case (w.action)
			ACT_ADD: begin num = an * bd + bn * ad; den = ad * bd; end
			ACT_SUB: begin num = an * bd - bn * ad; den = ad * bd; end
			ACT_MUL: begin num = an * bn; den = ad * bd; end
			ACT_DIV: begin num = an * bd; den = ad * bn; end
			default: begin
				p = an * bd;
				q = bn * ad;
				r.order = (p < q) ? ORD_LESS : ((p == q) ? ORD_EQUAL : ORD_GREAT);
				return r;
			end
		endcase
		if (den == 0) begin
			r.zero_divide = 1'b1;
			return r;
		end
		neg = (num < 0) != (den < 0);
		mn = (num < 0) ? longint'(-num) : num;
		md = (den < 0) ? longint'(-den) : den;
		g = euclid_gcd(mn, md);
		mn = mn / g;
		md = md / g;
		if (mn == 0) begin
			neg = 1'b0;
			md = 1;
		end
		lim = 64'd1 << 31;
		if (md > lim - 1 || mn > (neg ? lim : lim - 1))
			r.overflow = 1'b1;
		else begin
			r.r_num = 32'(neg ? -longint'(mn) : longint'(mn));
			r.r_den = md[30:0];
		end
		return r;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
	endtask

	// accepted word: queue the expectation
	always @(posedge clk) begin
		if (arst_n && start && !busy) begin
			if (driving_typed)
				fraction_q.push_back(driving_result);
			else
				fraction_q.push_back(reduce_fraction('{action, a_num, a_den, b_num, b_den}));
		end
	end

	always @(posedge clk) begin
		word_out_t e;
		if (arst_n && done) begin
			if (fraction_q.size() == 0) begin
				errors++;
				$display("unexpected result word at %0t", $realtime);
			end else begin
				e = fraction_q.pop_front();
				n_results++;
				if (e.overflow) n_ovf++;
				if (e.zero_divide) n_zdiv++;
				if (r_num !== e.r_num) report("r_num", r_num, e.r_num);
				if (r_den !== e.r_den) report("r_den", r_den, e.r_den);
				if (order !== e.order) report("order", order, e.order);
				if (zero_divide !== e.zero_divide) report("zero_divide", zero_divide, e.zero_divide);
				if (overflow !== e.overflow) report("overflow", overflow, e.overflow);
			end
		end
	end

	task automatic send_word(word_in_t w, bit typed, word_out_t r, bit may_idle);
		int gap;
		gap = (may_idle && $urandom_range(99) < 23) ? $urandom_range(1, 4) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		action <= w.action;
		a_num <= w.a_num;
		a_den <= w.a_den;
		b_num <= w.b_num;
		b_den <= w.b_den;
		driving_typed <= typed;
		driving_result <= r;
		start <= 1'b1;
		do @(posedge clk); while (busy);
	endtask

	function automatic word_in_t random_word();
		word_in_t w;
		int kind;
		kind = $urandom_range(99);
		w.action = ACT_W'($urandom_range(0, 7));
		if (kind < 55) begin
			w.a_num = $urandom;
			w.a_den = 31'($urandom);
			w.b_num = $urandom;
			w.b_den = 31'($urandom);
		end else if (kind < 90) begin
			w.a_num = $urandom_range(200) - 100;
			w.a_den = 31'($urandom_range(1, 100));
			w.b_num = $urandom_range(200) - 100;
			w.b_den = 31'($urandom_range(1, 100));
		end else begin
			w.a_num = ($urandom_range(1) != 0) ? 32'sd0 : $urandom;
			w.a_den = ($urandom_range(2) == 0) ? 31'd0 : 31'($urandom_range(1, 1000));
			w.b_num = ($urandom_range(1) != 0) ? 32'sd0 : $urandom;
			w.b_den = ($urandom_range(2) == 0) ? 31'd0 : 31'($urandom_range(1, 1000));
		end
		return w;
	endfunction

	initial begin
		table_row_t rows[$];
		word_out_t none;
		word_out_t zd;
		word_out_t ov;
		int n_items;
		none = '{r_num: '0, r_den: 31'd1, order: ORD_LESS, zero_divide: 1'b0, overflow: 1'b0};
		zd = none;
		zd.zero_divide = 1'b1;
		ov = none;
		ov.overflow = 1'b1;
		rows = '{
			'{'{ACT_ADD, 32'sd0, 31'd1, 32'sd0, 31'd1}, 1'b1, none},
			'{'{ACT_DIV, 32'sd1, 31'd1, 32'sd0, 31'd1}, 1'b1, zd},
			'{'{ACT_MUL, 32'sd3, 31'd0, 32'sd2, 31'd5}, 1'b1, zd},
			'{'{ACT_ADD, 32'sd1, 31'd2, 32'sd1, 31'd0}, 1'b1, zd},
			'{'{ACT_MUL, -32'sd2147483648, 31'd1, -32'sd2147483648, 31'd1}, 1'b1, ov},
			'{'{ACT_ADD, 32'sd2147483647, 31'd1, 32'sd1, 31'd1}, 1'b1, ov},
			'{'{ACT_SUB, -32'sd2147483648, 31'd1, 32'sd0, 31'd7}, 1'b0, none},
			'{'{ACT_SUB, -32'sd2147483648, 31'd1, 32'sd1, 31'd1}, 1'b1, ov},
			'{'{ACT_DIV, 32'sd1, 31'h7fffffff, 32'sd1, 31'h7fffffff}, 1'b0, none},
			'{'{ACT_DIV, 32'sd1, 31'h7fffffff, 32'sd2, 31'd1}, 1'b1, ov},
			'{'{ACT_CMP, 32'sd1, 31'd2, 32'sd2, 31'd4}, 1'b0, none},
			'{'{ACT_CMP, -32'sd1, 31'd2, 32'sd1, 31'd3}, 1'b0, none},
			'{'{ACT_CMP, 32'sd5, 31'd0, 32'sd1, 31'd0}, 1'b0, none},
			'{'{ACT_SPARE5, 32'sd3, 31'd4, 32'sd1, 31'd4}, 1'b0, none},
			'{'{ACT_SPARE7, 32'sd2147483647, 31'd1, -32'sd2147483648, 31'd1}, 1'b0, none},
			'{'{ACT_ADD, 32'sd1, 31'd6, 32'sd1, 31'd3}, 1'b0, none},
			'{'{ACT_SUB, 32'sd1, 31'd3, 32'sd1, 31'd3}, 1'b0, none},
			'{'{ACT_MUL, -32'sd6, 31'd35, 32'sd14, 31'd9}, 1'b0, none},
			'{'{ACT_DIV, 32'sd4, 31'd9, -32'sd2, 31'd3}, 1'b0, none},
			'{'{ACT_DIV, -32'sd2147483648, 31'd1, 32'sd1, 31'd1}, 1'b0, none},
			'{'{ACT_DIV, -32'sd2147483648, 31'd1, -32'sd1, 31'd1}, 1'b1, ov},
			'{'{ACT_MUL, 32'sd46341, 31'h7fffffff, 32'sd46341, 31'h7fffffff}, 1'b0, none}
		};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_word(rows[i].w, rows[i].typed, rows[i].r, 1'b1);
		for (int i = 0; i < N_RANDOM; i++)
			send_word(random_word(), 1'b0, none, !(i >= 600 && i < 900));
		start <= 1'b0;
		n_items = rows.size() + N_RANDOM;
		while (fraction_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		$display("covered %0d words: %0d results, %0d overflow, %0d divide by zero",
			n_items, n_results, n_ovf, n_zdiv);
		if (errors == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

	initial begin
		#(64'd500_000_000);
		$display("testbench: errors");
		$finish;
	end
endmodule
`default_nettype wire
